// File: rtl/core/vqncs_pkg.sv
// Shared constants, word types and controller interface types for the codeword search unit.
package vqncs_pkg;

    localparam int NUM_CODES   = 64;
    localparam int MAX_ORDER   = 32;
    localparam int VALUE_WIDTH = 16;

    localparam int CODE_W     = 6;
    localparam int ELEM_W     = 5;
    localparam int ORDER_W    = 6;
    localparam int NCODES_W   = 7;
    localparam int DIST_W     = 37;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int CODE_CNT_W = $clog2(NUM_CODES + 1);
    localparam int ELEM_CNT_W = $clog2(MAX_ORDER + 1);
    localparam int CODE_AW    = $clog2(NUM_CODES);
    localparam int ELEM_AW    = $clog2(MAX_ORDER);

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_ORDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODES_IN_USE = 2'd1;

    localparam logic [ORDER_W-1:0]  VECTOR_ORDER_RST = 6'd24;
    localparam logic [NCODES_W-1:0] CODES_IN_USE_RST = 7'd1;

    typedef struct packed {
        logic                          func;
        logic [CODE_W-1:0]             code_index;
        logic [ELEM_W-1:0]             element_index;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          empty_flag;
        logic                          last_element;
    } in_word_t;

    typedef struct packed {
        logic [CODE_W-1:0] best_index;
        logic [DIST_W-1:0] best_distance;
        logic              none_found;
    } out_word_t;

    typedef struct packed {
        logic store_item;
        logic search_init;
        logic code_begin;
        logic issue;
        logic compare;
        logic skip;
    } cmd_t;

    typedef struct packed {
        logic code_end;
        logic code_is_empty;
        logic elem_end;
        logic pipe_busy;
    } status_t;

endpackage

// File: rtl/core/vqncs_ctrl.sv
// Sequencer that walks the codebook entries and element positions of one search.
module vqncs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               func,
    input  logic               last_element,
    input  vqncs_pkg::status_t status,
    output vqncs_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               result_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CODE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign result_valid = done_reg;

    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        cmd             = '0;
        cmd.store_item  = accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == vqncs_pkg::FUNC_SAMPLE && last_element)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_CODE;
                end
            end
            ST_CODE:
            begin
                if (status.code_end)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (status.code_is_empty)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    cmd.code_begin = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (status.elem_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                // The accumulator holds the full distance once the pipeline is empty.
                if (!status.pipe_busy)
                begin
                    cmd.compare = 1'b1;
                    state_next  = ST_CODE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

// File: rtl/core/vqncs_dp.sv
// Stores, configuration registers, distance pipeline and best-entry tracking.
module vqncs_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  vqncs_pkg::in_word_t                  in_word,
    input  vqncs_pkg::cmd_t                      cmd,
    output vqncs_pkg::status_t                   status,
    input  logic                                 cfg_we,
    input  logic [vqncs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vqncs_pkg::CFG_DATA_W-1:0]     cfg_data,
    output vqncs_pkg::out_word_t                 result
);

    localparam int CB_DEPTH = vqncs_pkg::NUM_CODES * vqncs_pkg::MAX_ORDER;
    localparam int CB_AW    = $clog2(CB_DEPTH);
    localparam int VW       = vqncs_pkg::VALUE_WIDTH;
    localparam int DIFF_W   = VW + 1;
    localparam int SQ_W     = 2 * VW;
    localparam int DW       = vqncs_pkg::DIST_W;
    localparam int SUM_W    = DW + 1;

    logic [VW-1:0] codebook_mem [CB_DEPTH];
    logic [VW-1:0] sample_mem [vqncs_pkg::MAX_ORDER];
    logic [vqncs_pkg::NUM_CODES-1:0] empty_reg;

    logic [vqncs_pkg::ORDER_W-1:0]    order_cfg_reg;
    logic [vqncs_pkg::NCODES_W-1:0]   ncodes_cfg_reg;
    logic [vqncs_pkg::ORDER_W-1:0]    order_eff;
    logic [vqncs_pkg::NCODES_W-1:0]   ncodes_eff;

    logic [vqncs_pkg::CODE_CNT_W-1:0] code_reg;
    logic [vqncs_pkg::ELEM_CNT_W-1:0] elem_reg;

    logic [VW-1:0]     cb_rd_reg, smp_rd_reg;
    logic [DIFF_W-1:0] diff_reg, diff_neg;
    logic [VW-1:0]     mag;
    logic [SQ_W-1:0]   sq_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [DW-1:0]     acc_reg, best_d_reg;
    logic [SUM_W-1:0]  acc_sum;
    logic [vqncs_pkg::CODE_W-1:0] best_i_reg;
    logic              found_reg;

    logic [CB_AW-1:0]  wr_addr, rd_addr;
    logic              load_we, sample_we;

    assign order_eff  = (int'(order_cfg_reg) > vqncs_pkg::MAX_ORDER) ?
                        vqncs_pkg::ORDER_W'(vqncs_pkg::MAX_ORDER) : order_cfg_reg;
    assign ncodes_eff = (int'(ncodes_cfg_reg) > vqncs_pkg::NUM_CODES) ?
                        vqncs_pkg::NCODES_W'(vqncs_pkg::NUM_CODES) : ncodes_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_cfg_reg  <= vqncs_pkg::VECTOR_ORDER_RST;
            ncodes_cfg_reg <= vqncs_pkg::CODES_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == vqncs_pkg::CFG_VECTOR_ORDER)
            begin
                order_cfg_reg <= cfg_data[vqncs_pkg::ORDER_W-1:0];
            end
            else if (cfg_index == vqncs_pkg::CFG_CODES_IN_USE)
            begin
                ncodes_cfg_reg <= cfg_data[vqncs_pkg::NCODES_W-1:0];
            end
        end
    end

    assign load_we   = cmd.store_item && (in_word.func == vqncs_pkg::FUNC_LOAD) &&
                       (int'(in_word.code_index) < vqncs_pkg::NUM_CODES);
    assign sample_we = cmd.store_item && (in_word.func == vqncs_pkg::FUNC_SAMPLE) &&
                       (int'(in_word.element_index) < vqncs_pkg::MAX_ORDER);

    assign wr_addr = CB_AW'(in_word.code_index) * CB_AW'(vqncs_pkg::MAX_ORDER)
                   + CB_AW'(in_word.element_index);
    assign rd_addr = CB_AW'(code_reg[vqncs_pkg::CODE_AW-1:0]) * CB_AW'(vqncs_pkg::MAX_ORDER)
                   + CB_AW'(elem_reg[vqncs_pkg::ELEM_AW-1:0]);

    always_ff @(posedge clk)
    begin
        if (load_we && int'(in_word.element_index) < vqncs_pkg::MAX_ORDER)
        begin
            codebook_mem[wr_addr] <= in_word.value;
        end
        cb_rd_reg <= codebook_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sample_we)
        begin
            sample_mem[in_word.element_index[vqncs_pkg::ELEM_AW-1:0]] <= in_word.value;
        end
        smp_rd_reg <= sample_mem[elem_reg[vqncs_pkg::ELEM_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= '0;
        end
        else if (load_we)
        begin
            empty_reg[in_word.code_index[vqncs_pkg::CODE_AW-1:0]] <= in_word.empty_flag;
        end
    end

    // Element and entry counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= '0;
            elem_reg <= '0;
        end
        else
        begin
            if (cmd.search_init)
            begin
                code_reg <= '0;
            end
            else if (cmd.compare || cmd.skip)
            begin
                code_reg <= code_reg + vqncs_pkg::CODE_CNT_W'(1);
            end
            if (cmd.code_begin)
            begin
                elem_reg <= '0;
            end
            else if (cmd.issue)
            begin
                elem_reg <= elem_reg + vqncs_pkg::ELEM_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign diff_neg = -diff_reg;
    assign mag      = diff_reg[DIFF_W-1] ? diff_neg[VW-1:0] : diff_reg[VW-1:0];
    assign acc_sum  = {1'b0, acc_reg} + SUM_W'(sq_reg);

    always_ff @(posedge clk)
    begin
        diff_reg <= {cb_rd_reg[VW-1], cb_rd_reg} - {smp_rd_reg[VW-1], smp_rd_reg};
        sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
        if (cmd.code_begin)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_sum[DW] ? {DW{1'b1}} : acc_sum[DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_d_reg <= {DW{1'b1}};
            best_i_reg <= '0;
            found_reg  <= 1'b0;
        end
        else if (cmd.search_init)
        begin
            best_d_reg <= {DW{1'b1}};
            best_i_reg <= '0;
            found_reg  <= 1'b0;
        end
        else if (cmd.compare && (!found_reg || acc_reg < best_d_reg))
        begin
            // Strict less-than keeps the lower index on a tie.
            best_d_reg <= acc_reg;
            best_i_reg <= code_reg[vqncs_pkg::CODE_W-1:0];
            found_reg  <= 1'b1;
        end
    end

    assign status.code_end      = (vqncs_pkg::NCODES_W'(code_reg) >= ncodes_eff);
    assign status.code_is_empty = empty_reg[code_reg[vqncs_pkg::CODE_AW-1:0]];
    assign status.elem_end      = (vqncs_pkg::ORDER_W'(elem_reg) >= order_eff);
    assign status.pipe_busy     = v1_reg || v2_reg || v3_reg;

    assign result.best_index    = best_i_reg;
    assign result.best_distance = best_d_reg;
    assign result.none_found    = !found_reg;

endmodule

// File: rtl/core/vq_nearest_codeword_search_unit.sv
// Top level of the vector-quantizer nearest-codeword search unit.
//
//  channel   handshake                    word
//  -------   ---------------------------  -----------------------------
//  input     start && !busy               in_word  (vqncs_pkg::in_word_t)
//  result    result_valid, one cycle      result   (vqncs_pkg::out_word_t)
//  config    cfg_valid && cfg_ready       cfg_index, cfg_data
//
// Load words and sample words without the last flag are stored at once; busy stays low.
// A last sample word starts a search that walks each searched entry in turn, skipping any
// entry that is marked empty, all through a
// single multiply-accumulate pipeline fed by one codebook read port.
// The result strobe is high in the same cycle that busy falls; the receiver cannot stall it.
// Reset clears the empty marks and sets the configuration to its defaults at once; no clearing pass is needed.
module vq_nearest_codeword_search_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  vqncs_pkg::in_word_t               in_word,
    output logic                              result_valid,
    output vqncs_pkg::out_word_t              result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vqncs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vqncs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    vqncs_pkg::cmd_t    cmd;
    vqncs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    vqncs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (in_word.func),
        .last_element (in_word.last_element),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    vqncs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result)
    );

`ifndef SYNTH
    a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while a search is running");

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_word.func == vqncs_pkg::FUNC_SAMPLE && in_word.last_element)
        |=> busy)
        else $error("last sample word did not start a search");

    a_none_found_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.none_found) |->
        (result.best_distance == {vqncs_pkg::DIST_W{1'b1}} && result.best_index == '0))
        else $error("empty search result carries a distance or index");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && in_word.func == vqncs_pkg::FUNC_LOAD) |=> !busy && !result_valid)
        else $error("load word caused a search or result");
`endif

endmodule

// File: dv/tb_vq_nearest_codeword_search_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the vector-quantizer nearest-codeword search unit.
module tb_vq_nearest_codeword_search_unit;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int STALL_LIMIT   = 10000;
    localparam int PHASE_WORDS   = 125;
    localparam int NUM_PHASES    = 8;

    localparam int NUM_CODES   = vqncs_pkg::NUM_CODES;
    localparam int MAX_ORDER   = vqncs_pkg::MAX_ORDER;
    localparam int VALUE_WIDTH = vqncs_pkg::VALUE_WIDTH;

    localparam logic [vqncs_pkg::CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam logic [vqncs_pkg::DIST_W-1:0]    DIST_ALL_ONES = '1;
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    class codeword_scoreboard;
        logic signed [VALUE_WIDTH-1:0]     codebook [NUM_CODES][MAX_ORDER];
        logic signed [VALUE_WIDTH-1:0]     frame [MAX_ORDER];
        bit                                empty_mark [NUM_CODES];
        logic [vqncs_pkg::ORDER_W-1:0]     order_reg;
        logic [vqncs_pkg::NCODES_W-1:0]    codes_reg;
        vqncs_pkg::out_word_t              expected_labels [$];
        int                                errors;
        int                                n_loads;
        int                                n_searches;
        int                                n_none;
        int                                n_ties;

        function new();
            order_reg = vqncs_pkg::VECTOR_ORDER_RST;
            codes_reg = vqncs_pkg::CODES_IN_USE_RST;
        endfunction

        function void set_reg(logic [vqncs_pkg::CFG_IDX_W-1:0] idx,
                              logic [vqncs_pkg::CFG_DATA_W-1:0] data);
            if (idx == vqncs_pkg::CFG_VECTOR_ORDER)
                order_reg = data[vqncs_pkg::ORDER_W-1:0];
            else if (idx == vqncs_pkg::CFG_CODES_IN_USE)
                codes_reg = data[vqncs_pkg::NCODES_W-1:0];
        endfunction

        function int searched_order();
            return (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
        endfunction

        function int searched_codes();
            return (codes_reg > NUM_CODES) ? NUM_CODES : int'(codes_reg);
        endfunction

        function logic [vqncs_pkg::DIST_W-1:0] squared_distance(int code);
            longint acc;
            longint diff;
            acc = 0;
            for (int e = 0; e < searched_order(); e++)
            begin
                diff = longint'(codebook[code][e]) - longint'(frame[e]);
                acc += diff * diff;
                if (acc > longint'(DIST_ALL_ONES))
                    acc = longint'(DIST_ALL_ONES);
            end
            return acc[vqncs_pkg::DIST_W-1:0];
        endfunction

        // Applies one accepted word and queues the label that a search must produce.
        function void note_word(vqncs_pkg::in_word_t w);
            vqncs_pkg::out_word_t          label;
            logic [vqncs_pkg::DIST_W-1:0]  distance;
            if (w.func == vqncs_pkg::FUNC_LOAD)
            begin
                codebook[w.code_index][w.element_index] = w.value;
                empty_mark[w.code_index] = w.empty_flag;
                n_loads++;
            end
            else
            begin
                frame[w.element_index] = w.value;
                if (w.last_element)
                begin
                    label.best_index    = '0;
                    label.best_distance = DIST_ALL_ONES;
                    label.none_found    = 1'b1;
                    for (int c = 0; c < searched_codes(); c++)
                    begin
                        if (!empty_mark[c])
                        begin
                            distance = squared_distance(c);
                            if (!label.none_found && distance == label.best_distance)
                                n_ties++;
                            // Strictly smaller only, so the lower index keeps a tie.
                            if (label.none_found || distance < label.best_distance)
                            begin
                                label.best_index    = vqncs_pkg::CODE_W'(c);
                                label.best_distance = distance;
                                label.none_found    = 1'b0;
                            end
                        end
                    end
                    n_searches++;
                    if (label.none_found)
                        n_none++;
                    expected_labels.push_back(label);
                end
            end
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_label(vqncs_pkg::out_word_t got);
            vqncs_pkg::out_word_t want;
            if (expected_labels.size() == 0)
                report($sformatf("result index %0d distance %0d none %0b with no search pending",
                                 got.best_index, got.best_distance, got.none_found));
            else
            begin
                want = expected_labels.pop_front();
                if (got.best_index !== want.best_index)
                    report($sformatf("best_index %0d, expected %0d",
                                     got.best_index, want.best_index));
                if (got.best_distance !== want.best_distance)
                    report($sformatf("best_distance %0d, expected %0d",
                                     got.best_distance, want.best_distance));
                if (got.none_found !== want.none_found)
                    report($sformatf("none_found %0b, expected %0b",
                                     got.none_found, want.none_found));
            end
        endtask
    endclass

    logic                                 clk       = 1'b0;
    logic                                 rst_n     = 1'b0;
    logic                                 start     = 1'b0;
    logic                                 busy;
    vqncs_pkg::in_word_t                  in_word   = '0;
    logic                                 result_valid;
    vqncs_pkg::out_word_t                 result;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [vqncs_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [vqncs_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    codeword_scoreboard sb;
    bit                 cb_written [NUM_CODES][MAX_ORDER];
    bit                 frame_written [MAX_ORDER];
    bit                 idle_on = 1'b0;
    int                 idle_pct = 0;
    int                 n_words = 0;
    int                 n_cfg = 0;
    int                 stall_cycles = 0;
    int                 phase_order [NUM_PHASES] = '{8, 1, 32, 127, 3, 24, 5, 33};
    int                 phase_codes [NUM_PHASES] = '{4, 64, 16, 127, 0, 1, 65, 8};

    vq_nearest_codeword_search_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_word      (in_word),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            sb.check_label(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_vq_nearest_codeword_search_unit failed");
            $finish;
        end
    end

    function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
        int v;
        case ($urandom_range(0, 7))
            0: v = int'(VALUE_MIN);
            1: v = int'(VALUE_MAX);
            2, 3: v = $urandom_range(0, (1 << VALUE_WIDTH) - 1);
            default: v = int'($urandom_range(0, 12)) - 6;
        endcase
        return v[VALUE_WIDTH-1:0];
    endfunction

    function automatic int pick_code();
        int nc;
        nc = sb.searched_codes();
        return (nc == 0) ? $urandom_range(0, NUM_CODES - 1) : $urandom_range(0, nc - 1);
    endfunction

    task automatic send_word(vqncs_pkg::in_word_t w);
        if (idle_on && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        start   <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        sb.note_word(w);
        n_words++;
        if (w.func == vqncs_pkg::FUNC_LOAD)
            cb_written[w.code_index][w.element_index] = 1'b1;
        else
            frame_written[w.element_index] = 1'b1;
    endtask

    task automatic send_load(int code, int elem, logic signed [VALUE_WIDTH-1:0] v, logic empty);
        vqncs_pkg::in_word_t w;
        w.func          = vqncs_pkg::FUNC_LOAD;
        w.code_index    = vqncs_pkg::CODE_W'(code);
        w.element_index = vqncs_pkg::ELEM_W'(elem);
        w.value         = v;
        w.empty_flag    = empty;
        w.last_element  = 1'($urandom_range(0, 1));
        send_word(w);
    endtask

    task automatic send_sample(int elem, logic signed [VALUE_WIDTH-1:0] v, logic last);
        vqncs_pkg::in_word_t w;
        w.func          = vqncs_pkg::FUNC_SAMPLE;
        w.code_index    = vqncs_pkg::CODE_W'($urandom_range(0, NUM_CODES - 1));
        w.element_index = vqncs_pkg::ELEM_W'(elem);
        w.value         = v;
        w.empty_flag    = 1'($urandom_range(0, 1));
        w.last_element  = last;
        send_word(w);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.expected_labels.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [vqncs_pkg::CFG_IDX_W-1:0] idx,
                             logic [vqncs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        sb.set_reg(idx, data);
        n_cfg++;
    endtask

    task automatic set_config(int order, int codes, bit with_unused);
        drain();
        if (with_unused)
            write_reg(CFG_UNUSED,
                      vqncs_pkg::CFG_DATA_W'($urandom_range(0, (1 << vqncs_pkg::CFG_DATA_W) - 1)));
        write_reg(vqncs_pkg::CFG_VECTOR_ORDER, vqncs_pkg::CFG_DATA_W'(order));
        write_reg(vqncs_pkg::CFG_CODES_IN_USE, vqncs_pkg::CFG_DATA_W'(codes));
        cfg_valid <= 1'b0;
    endtask

    // Makes sure the coming search reads only written elements. A searched entry with
    // many holes is usually marked empty instead of filled, to keep the word count down.
    task automatic prepare_search();
        int ord;
        int missing;
        ord = sb.searched_order();
        for (int e = 0; e < ord; e++)
            if (!frame_written[e])
                send_sample(e, rand_value(), 1'b0);
        for (int c = 0; c < sb.searched_codes(); c++)
        begin
            if (!sb.empty_mark[c])
            begin
                missing = 0;
                for (int e = 0; e < ord; e++)
                    missing += !cb_written[c][e];
                if (missing > 0 && (missing <= 8 || $urandom_range(0, 7) == 0))
                begin
                    for (int e = 0; e < ord; e++)
                        if (!cb_written[c][e])
                            send_load(c, e, rand_value(), 1'b0);
                end
                else if (missing > 0)
                    send_load(c, 0, rand_value(), 1'b1);
            end
        end
    endtask

    task automatic run_frame(bit well_formed);
        int ord;
        int span;
        int len;
        int rot;
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
        ord  = sb.searched_order();
        span = (ord == 0) ? 1 : ord;
        repeat ($urandom_range(0, 2))
            send_load(pick_code(), $urandom_range(0, span - 1), rand_value(),
                      $urandom_range(0, 9) == 0);
        len = well_formed ? span : $urandom_range(1, span);
        rot = $urandom_range(0, span - 1);
        for (int k = 0; k < len - 1; k++)
            send_sample((k + rot) % span, rand_value(), 1'b0);
        prepare_search();
        send_sample((len - 1 + rot) % span, rand_value(),
                    well_formed ? 1'b1 : 1'($urandom_range(0, 1)));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 4))
            if ($urandom_range(0, 1))
                send_load($urandom_range(0, NUM_CODES - 1), $urandom_range(0, MAX_ORDER - 1),
                          rand_value(), 1'($urandom_range(0, 1)));
            else
                send_sample($urandom_range(0, MAX_ORDER - 1), rand_value(), 1'b0);
    endtask

    initial
    begin
        int target;
        int pick;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with one-element vectors over three entries.
        set_config(1, 3, 1'b0);
        send_load(0, 0, VALUE_MIN, 1'b0);
        send_load(1, 0, VALUE_MAX, 1'b0);
        send_load(2, 0, VALUE_MAX, 1'b0);
        send_load(NUM_CODES - 1, MAX_ORDER - 1, VALUE_MIN, 1'b1);
        // Entries one and two are equally near; the lower index must win.
        send_sample(0, VALUE_MAX, 1'b1);
        send_sample(0, VALUE_MIN, 1'b1);
        send_sample(0, '0, 1'b1);
        send_load(1, 0, VALUE_MAX, 1'b1);
        send_sample(0, VALUE_MAX, 1'b1);
        send_load(0, 0, VALUE_MIN, 1'b1);
        send_load(2, 0, VALUE_MAX, 1'b1);
        send_sample(0, 16'sd5, 1'b1);
        // With no elements compared, the first non-empty entry is at distance zero.
        set_config(0, 3, 1'b1);
        send_load(2, 0, 16'sd100, 1'b0);
        send_sample(0, -16'sd1, 1'b1);
        set_config(1, 0, 1'b0);
        send_sample(0, 16'sd7, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_config(phase_order[p], phase_codes[p], p == 3);
            idle_on = (p < NUM_PHASES - 1);
            target  = n_words + PHASE_WORDS;
            while (n_words < target)
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    drain();
                else if (pick < 15)
                    run_frame(1'b1);
                else if (pick < 17)
                    run_frame(1'b0);
                else
                    send_noise();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.expected_labels.size() != 0)
            sb.report($sformatf("%0d searches never answered", sb.expected_labels.size()));
        $display("Sent %0d words (%0d codebook loads) with %0d register writes.",
                 n_words, sb.n_loads, n_cfg);
        $display("Checked %0d searches: %0d with no candidate, %0d equal-distance candidates.",
                 sb.n_searches, sb.n_none, sb.n_ties);
        if (sb.errors == 0)
            $display("tb_vq_nearest_codeword_search_unit passed");
        else
            $display("tb_vq_nearest_codeword_search_unit failed");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/vqncs_pkg.sv
rtl/core/vqncs_ctrl.sv
rtl/core/vqncs_dp.sv
rtl/core/vq_nearest_codeword_search_unit.sv
dv/tb_vq_nearest_codeword_search_unit.sv
